/* rtl/pct_pkg.sv */
package pct_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_KEY     = 2'd2,
        MODE_STRING  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_COMMENT = 2'd0,
        KIND_KEY     = 2'd1,
        KIND_STRING  = 2'd2
    } t_kind;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    typedef struct packed {
        t_mode      mode;
        logic       esc;
        logic [7:0] quote;
        logic       pending;
    } t_state;

    typedef struct packed {
        logic       append_valid;
        logic [7:0] append_byte;
        logic       token_valid;
        t_kind      token_kind;
        logic       token_takes_text;
        logic [7:0] token_quote;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_key(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c == CH_DASH) || (c == CH_LBRK) || (c == CH_RBRK);
    endfunction

endpackage

/* rtl/pct_step.sv */
module pct_step (
    input  logic [7:0]       i_byte,
    input  pct_pkg::t_state  i_state,
    output pct_pkg::t_state  o_state,
    output pct_pkg::t_result o_result
);
    import pct_pkg::*;

    logic use_idle;

    always_comb begin
        o_state  = i_state;
        o_result = '{append_valid: 1'b0, append_byte: 8'h00, token_valid: 1'b0,
                     token_kind: KIND_COMMENT, token_takes_text: 1'b0,
                     token_quote: 8'h00};
        use_idle = 1'b0;

        case (i_state.mode)
            MODE_IDLE: begin
                use_idle = 1'b1;
            end
            MODE_COMMENT: begin
                if (i_byte == CH_LF) begin
                    o_result.token_valid      = 1'b1;
                    o_result.token_kind       = KIND_COMMENT;
                    o_result.token_takes_text = 1'b1;
                    o_state.pending           = 1'b0;
                    o_state.mode              = MODE_IDLE;
                end else if (i_byte != CH_CR) begin
                    o_result.append_valid = 1'b1;
                    o_result.append_byte  = i_byte;
                    o_state.pending       = 1'b1;
                end
            end
            MODE_KEY: begin
                if (is_key(i_byte)) begin
                    o_result.append_valid = 1'b1;
                    o_result.append_byte  = i_byte;
                    o_state.pending       = 1'b1;
                end else begin
                    o_state.mode = MODE_IDLE;
                    use_idle     = 1'b1;
                end
            end
            default: begin
                if (i_state.esc) begin
                    o_state.esc = 1'b0;
                    if (i_byte == CH_LOW_T) begin
                        o_result.append_valid = 1'b1;
                        o_result.append_byte  = CH_TAB;
                        o_state.pending       = 1'b1;
                    end else if (i_byte == CH_LOW_N) begin
                        o_result.append_valid = 1'b1;
                        o_result.append_byte  = CH_LF;
                        o_state.pending       = 1'b1;
                    end else if (i_byte == CH_LOW_R) begin
                        o_result.append_valid = 1'b1;
                        o_result.append_byte  = CH_CR;
                        o_state.pending       = 1'b1;
                    end
                end else if (i_byte == i_state.quote) begin
                    o_result.token_valid      = 1'b1;
                    o_result.token_kind       = KIND_STRING;
                    o_result.token_takes_text = 1'b1;
                    o_result.token_quote      = i_state.quote;
                    o_state.pending           = 1'b0;
                    o_state.mode              = MODE_IDLE;
                end else if (i_byte == CH_BSLASH) begin
                    o_state.esc = 1'b1;
                end else begin
                    o_result.append_valid = 1'b1;
                    o_result.append_byte  = i_byte;
                    o_state.pending       = 1'b1;
                end
            end
        endcase

        // idle handling, also reached by a key that ends on a non-key byte
        if (use_idle) begin
            if (i_byte == CH_SQUOTE || i_byte == CH_DQUOTE) begin
                o_state.mode  = MODE_STRING;
                o_state.quote = i_byte;
            end else if (i_byte == CH_HASH) begin
                o_state.mode         = MODE_COMMENT;
                o_result.token_valid = 1'b1;
                o_result.token_kind  = KIND_COMMENT;
            end else if (!is_space(i_byte)) begin
                o_state.mode          = MODE_KEY;
                o_result.append_valid = 1'b1;
                o_result.append_byte  = i_byte;
                o_state.pending       = 1'b1;
            end else if (i_state.pending) begin
                o_result.token_valid      = 1'b1;
                o_result.token_kind       = KIND_KEY;
                o_result.token_takes_text = 1'b1;
                o_state.pending           = 1'b0;
            end
        end
    end

endmodule

/* rtl/po_catalog_tokenizer.sv */
// channel | dir | handshake                  | payload
// in      | in  | i_in_valid / o_in_ready    | i_in_byte
// out     | out | o_out_valid / i_out_ready  | o_append_*, o_token_*
//
// One request per cycle sustained while the output is not stalled; a byte taken
// is held in the input register, then moves into the result register, which offers its result.
// The lexer step sits between the two registers and updates the mode state
// when the byte moves into the result register.
// Synchronous active-low reset clears the valids and the lexer state.
// A stalled output holds the result register and a full input register; input ready drops only then.
module po_catalog_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_append_valid,
    output logic [7:0] o_append_byte,
    output logic       o_token_valid,
    output logic [1:0] o_token_kind,
    output logic       o_token_takes_text,
    output logic [7:0] o_token_quote
);
    import pct_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_res;
    t_result    n_res;
    logic       advance;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    pct_step u_step (
        .i_byte   (r_in_byte),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{mode: MODE_IDLE, esc: 1'b0, quote: 8'h00, pending: 1'b0};
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
        if (advance && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_append_valid     = r_res.append_valid;
    assign o_append_byte      = r_res.append_byte;
    assign o_token_valid      = r_res.token_valid;
    assign o_token_kind       = r_res.token_kind;
    assign o_token_takes_text = r_res.token_takes_text;
    assign o_token_quote      = r_res.token_quote;

endmodule
